>>> rtl/boc_pkg.sv
// Shared types and constants for the box overlap collision scan.
// Used by the channel interfaces, the controller, the datapath and the top level.
package boc_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_W    = 8;
    localparam int EDGE_W    = 16;
    localparam int CFG_W     = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     flag;
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] bottom;
    } t_entry;

    // table read address source
    typedef enum logic [1:0] {
        RD_QUERY,
        RD_FIRST,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    wr_en;
        logic    q_start;
        logic    q_load;
        logic    scan_first;
        logic    scan_step;
        logic    res_hit;
        logic    res_miss;
        logic    out_load;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic q_active;
        logic limit_zero;
        logic match;
        logic scan_last;
        logic out_free;
    } t_sts;

    // inclusive overlap test on the left, right, top and bottom edges
    function automatic logic boxes_overlap(input t_entry a, input t_entry b);
        boxes_overlap = (a.right >= b.left) && (a.left <= b.right) &&
                        (a.top <= b.bottom) && (a.bottom >= b.top);
    endfunction

endpackage

>>> rtl/boc_in_if.sv
// Input channel: valid/ready handshake carrying one write or query word.
// Depends on boc_pkg for field widths.
interface boc_in_if;
    import boc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [SLOT_W-1:0]        slot;
    logic signed [EDGE_W-1:0] pos_x;
    logic signed [EDGE_W-1:0] pos_y;
    logic signed [EDGE_W-1:0] box_min_x;
    logic signed [EDGE_W-1:0] box_max_x;
    logic signed [EDGE_W-1:0] box_min_y;
    logic signed [EDGE_W-1:0] box_max_y;
    logic                     collides;

    modport source (
        output valid, op, slot, pos_x, pos_y, box_min_x, box_max_x,
               box_min_y, box_max_y, collides,
        input  ready
    );
    modport sink (
        input  valid, op, slot, pos_x, pos_y, box_min_x, box_max_x,
               box_min_y, box_max_y, collides,
        output ready
    );
endinterface

>>> rtl/boc_out_if.sv
// Result channel: valid/ready handshake carrying one query result word.
// Depends on boc_pkg for field widths.
interface boc_out_if;
    import boc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;

    modport source (output valid, hit, hit_slot, input ready);
    modport sink   (input valid, hit, hit_slot, output ready);
endinterface

>>> rtl/boc_ctrl.sv
// Controller state machine: sequences table writes, query load, scan and emit.
// Depends on boc_pkg for the state, command and status types.
module boc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  boc_pkg::t_sts i_sts,
    output boc_pkg::t_cmd o_cmd
);
    import boc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid && i_sts.in_op == OP_QUERY) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_sts.q_active || i_sts.limit_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.match || i_sts.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_QUERY;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.wr_en   = (i_sts.in_op == OP_WRITE);
                    o_cmd.q_start = (i_sts.in_op == OP_QUERY);
                end
            end
            S_LOAD: begin
                o_cmd.q_load = 1'b1;
                o_cmd.rd_sel = RD_FIRST;
                if (!i_sts.q_active || i_sts.limit_zero) begin
                    o_cmd.res_miss = 1'b1;
                end else begin
                    o_cmd.scan_first = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.rd_sel = RD_NEXT;
                priority if (i_sts.match) begin
                    o_cmd.res_hit = 1'b1;
                end else if (i_sts.scan_last) begin
                    o_cmd.res_miss = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd.rd_sel = RD_QUERY;
        endcase
    end

endmodule

>>> rtl/boc_dp.sv
// Datapath: box table memory, edge adders, query box, scan index, compare and
// output register. Depends on boc_pkg and the two channel interfaces.
module boc_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [boc_pkg::CFG_W-1:0] i_cfg_wdata,
    boc_in_if.sink                   i_in,
    boc_out_if.source                o_out,
    input  boc_pkg::t_cmd            i_cmd,
    output boc_pkg::t_sts            o_sts
);
    import boc_pkg::*;

    t_entry                r_mem [MAX_SLOTS];
    t_entry                r_rd_data;
    t_entry                r_qbox;
    t_entry                w_wr_entry;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [ADDR_W-1:0]     r_cmp;
    logic [ADDR_W-1:0]     r_qaddr;
    logic [SLOT_W-1:0]     r_qslot;
    logic                  r_q_ok;
    logic [CFG_W-1:0]      r_active_count;
    logic [CNT_W-1:0]      w_limit;
    logic                  w_slot_ok;
    logic                  r_res_hit;
    logic [SLOT_W-1:0]     r_res_slot;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;

    assign w_slot_ok = (int'(i_in.slot) < MAX_SLOTS);

    assign w_wr_entry.flag   = i_in.collides;
    assign w_wr_entry.left   = i_in.pos_x + i_in.box_min_x;
    assign w_wr_entry.right  = i_in.pos_x + i_in.box_max_x;
    assign w_wr_entry.top    = i_in.pos_y + i_in.box_min_y;
    assign w_wr_entry.bottom = i_in.pos_y + i_in.box_max_y;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_QUERY: w_rd_addr = ADDR_W'(i_in.slot);
            RD_FIRST: w_rd_addr = '0;
            RD_NEXT:  w_rd_addr = r_cmp + ADDR_W'(1);
            default:  w_rd_addr = '0;
        endcase
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_slot_ok) begin
            r_mem[ADDR_W'(i_in.slot)] <= w_wr_entry;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
        end else if (i_cfg_we) begin
            r_active_count <= i_cfg_wdata;
        end
    end

    // saturate the scan length at the table depth
    assign w_limit = (int'(r_active_count) >= MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                        : CNT_W'(r_active_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_qslot <= i_in.slot;
            r_qaddr <= ADDR_W'(i_in.slot);
            r_q_ok  <= w_slot_ok;
        end
        if (i_cmd.q_load) begin
            r_qbox <= r_rd_data;
        end
        if (i_cmd.scan_first) begin
            r_cmp <= '0;
        end else if (i_cmd.scan_step) begin
            r_cmp <= r_cmp + ADDR_W'(1);
        end
        if (i_cmd.res_hit) begin
            r_res_hit  <= 1'b1;
            r_res_slot <= SLOT_W'(r_cmp);
        end else if (i_cmd.res_miss) begin
            r_res_hit  <= 1'b0;
            r_res_slot <= r_qslot;
        end
    end

    // output register, freed by the receiver's handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_slot <= r_res_slot;
        end
    end

    assign i_in.ready     = i_cmd.in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.hit      = r_out_hit;
    assign o_out.hit_slot = r_out_slot;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.in_op      = i_in.op;
    assign o_sts.q_active   = r_q_ok && r_rd_data.flag;
    assign o_sts.limit_zero = (w_limit == '0);
    assign o_sts.match      = r_rd_data.flag && (r_cmp != r_qaddr) &&
                              boxes_overlap(r_qbox, r_rd_data);
    assign o_sts.scan_last  = ((CNT_W'(r_cmp) + CNT_W'(1)) >= w_limit);
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

endmodule

>>> rtl/box_overlap_collision_scan.sv
// Box overlap collision scan, top level: controller plus datapath.
// Depends on boc_pkg, boc_in_if, boc_out_if, boc_ctrl and boc_dp.
//
// Input channel i_in carries one word per handshake. A write word (op 0) stores
// one table entry, edges being position plus offset wrapped to 16 bits, and
// gives no result; writes are taken one per cycle while no query is in progress. A
// query word (op 1) scans slots 0 to active_count-1 (at most 255) in order for
// the first enabled slot, not the queried one, whose box overlaps the queried box,
// and gives one result word on o_out. A query holds the input while it loads
// the queried box, compares up to 256 slots (none when its flag is clear or
// active_count is 0) and emits: the table memory has one read port and the
// scan reads one entry per cycle. The result is loaded as the input is released.
// The output register decouples the sides: the next word is taken while a
// result waits. A stalled receiver holds the result; a following query then
// waits in its emit state until the register frees up.
// Reset (i_rst_n, synchronous) clears the controller, the output register and
// active_count. Table entries are undefined until written; no clearing pass.
// i_cfg_wdata writes active_count on i_cfg_we; the user must do so while the block is idle (not enforced).
module box_overlap_collision_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [boc_pkg::CFG_W-1:0] i_cfg_wdata,
    boc_in_if.sink                    i_in,
    boc_out_if.source                 o_out
);
    import boc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    boc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    boc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

>>> bench/box_overlap_collision_scan_check.sv
// Scoreboard for the box overlap collision scan: mirrors the box table and active_count,
// predicts each query result and compares it with the word seen on the result channel.
// Depends on boc_pkg, boc_in_if and boc_out_if.
module box_overlap_collision_scan_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [boc_pkg::CFG_W-1:0] i_cfg_wdata,
    boc_in_if                         i_in,
    boc_out_if                        i_res,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import boc_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
    } t_scan_result;

    logic signed [EDGE_W-1:0] left_edge   [MAX_SLOTS];
    logic signed [EDGE_W-1:0] right_edge  [MAX_SLOTS];
    logic signed [EDGE_W-1:0] top_edge    [MAX_SLOTS];
    logic signed [EDGE_W-1:0] bottom_edge [MAX_SLOTS];
    logic                     solid       [MAX_SLOTS];
    logic [CFG_W-1:0]         slot_count;
    t_scan_result             hit_q[$];
    int                       fail_count = 0;

    function automatic logic boxes_touch(input int a, input int b);
        return (right_edge[a] >= left_edge[b]) && (left_edge[a] <= right_edge[b]) &&
               (top_edge[a] <= bottom_edge[b]) && (bottom_edge[a] >= top_edge[b]);
    endfunction

    function automatic t_scan_result scan_table(input logic [SLOT_W-1:0] q);
        t_scan_result r;
        int           span;
        r.hit      = 1'b0;
        r.hit_slot = q;
        if (!solid[q])
            return r;
        // counts past the table size scan the whole table
        span = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
        for (int i = 0; i < span; i++) begin
            if (i != int'(q) && solid[i] && boxes_touch(int'(q), i)) begin
                r.hit      = 1'b1;
                r.hit_slot = SLOT_W'(i);
                return r;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            slot_count = '0;
            hit_q.delete();
        end else begin
            if (i_cfg_we)
                slot_count = i_cfg_wdata;
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == OP_WRITE) begin
                    // edges wrap to 16 bits
                    left_edge[i_in.slot]   = i_in.pos_x + i_in.box_min_x;
                    right_edge[i_in.slot]  = i_in.pos_x + i_in.box_max_x;
                    top_edge[i_in.slot]    = i_in.pos_y + i_in.box_min_y;
                    bottom_edge[i_in.slot] = i_in.pos_y + i_in.box_max_y;
                    solid[i_in.slot]       = i_in.collides;
                end else begin
                    hit_q.push_back(scan_table(i_in.slot));
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (hit_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing pending: hit=%0b slot=%0d",
                                 $realtime, i_res.hit, i_res.hit_slot);
                end else begin
                    want = hit_q.pop_front();
                    if (i_res.hit !== want.hit || i_res.hit_slot !== want.hit_slot) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                                     $realtime, want.hit, want.hit_slot,
                                     i_res.hit, i_res.hit_slot);
                    end
                end
            end
        end
        o_pending    <= hit_q.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> bench/box_overlap_collision_scan_test.sv
// Testbench top for the box overlap collision scan: clock, reset, config writes,
// directed and random write/query words, result back-pressure and the verdict.
// Depends on boc_pkg, boc_in_if, boc_out_if, the block and box_overlap_collision_scan_check.
module box_overlap_collision_scan_test;
    timeunit 1ns;
    timeprecision 1ps;
    import boc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic signed [EDGE_W-1:0] pos_x;
        logic signed [EDGE_W-1:0] pos_y;
        logic signed [EDGE_W-1:0] min_x;
        logic signed [EDGE_W-1:0] max_x;
        logic signed [EDGE_W-1:0] min_y;
        logic signed [EDGE_W-1:0] max_y;
        logic                     collides;
    } t_box_word;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               recv_stall_left = 0;
    bit               slot_written [MAX_SLOTS];
    int               written_slots[$];

    boc_in_if  in_ch ();
    boc_out_if res_ch ();

    box_overlap_collision_scan u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (res_ch)
    );

    box_overlap_collision_scan_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side drops ready in short random bursts, at a chance of recv_stall_pct
    always @(posedge clk) begin
        if (recv_stall_left > 0) begin
            res_ch.ready    <= 1'b0;
            recv_stall_left <= recv_stall_left - 1;
        end else if (int'($urandom_range(99)) < recv_stall_pct) begin
            res_ch.ready    <= 1'b0;
            recv_stall_left <= $urandom_range(2, 0);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    function automatic t_box_word box_write(input int slot, input int px, input int py,
                                            input int mnx, input int mxx, input int mny,
                                            input int mxy, input logic col);
        t_box_word w;
        w.op       = OP_WRITE;
        w.slot     = SLOT_W'(slot);
        w.pos_x    = EDGE_W'(px);
        w.pos_y    = EDGE_W'(py);
        w.min_x    = EDGE_W'(mnx);
        w.max_x    = EDGE_W'(mxx);
        w.min_y    = EDGE_W'(mny);
        w.max_y    = EDGE_W'(mxy);
        w.collides = col;
        return w;
    endfunction

    // payload fields other than the slot are don't-care on a query; keep them toggling
    function automatic t_box_word box_query(input int slot);
        t_box_word w;
        w = box_write(slot, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom_range(1));
        w.op = OP_QUERY;
        return w;
    endfunction

    // mostly sane boxes inside a window, some raw noise with wrapping edges
    function automatic t_box_word random_box(input int span, input int reach);
        if ($urandom_range(99) < 15)
            return box_write($urandom_range(MAX_SLOTS-1), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom_range(1));
        return box_write($urandom_range(MAX_SLOTS-1),
                         int'($urandom_range(2*span)) - span,
                         int'($urandom_range(2*span)) - span,
                         -int'($urandom_range(reach)), $urandom_range(reach),
                         -int'($urandom_range(reach)), $urandom_range(reach),
                         $urandom_range(99) < 85);
    endfunction

    task automatic send_word(input t_box_word w);
        if (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= w.op;
        in_ch.slot      <= w.slot;
        in_ch.pos_x     <= w.pos_x;
        in_ch.pos_y     <= w.pos_y;
        in_ch.box_min_x <= w.min_x;
        in_ch.box_max_x <= w.max_x;
        in_ch.box_min_y <= w.min_y;
        in_ch.box_max_y <= w.max_y;
        in_ch.collides  <= w.collides;
        do @(posedge clk); while (!in_ch.ready);
        if (w.op == OP_WRITE && !slot_written[w.slot]) begin
            slot_written[w.slot] = 1'b1;
            written_slots.push_back(int'(w.slot));
        end
    endtask

    // hold off until every query has answered and the last write has settled
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_slot_count(input int count);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int words, input int span,
                             input int reach, input bit calm);
        t_box_word w;
        set_slot_count(count);
        if (calm) begin
            send_idle_pct  <= 0;
            recv_stall_pct <= 0;
        end else begin
            send_idle_pct  <= 10 * $urandom_range(4);
            recv_stall_pct <= 10 * $urandom_range(4);
        end
        // every slot the scan reads must hold a written entry
        for (int s = 0; s < count && s < MAX_SLOTS; s++) begin
            if (!slot_written[s]) begin
                w      = random_box(span, reach);
                w.slot = SLOT_W'(s);
                send_word(w);
            end
        end
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(99) < 45)
                send_word(box_query(written_slots[$urandom_range(written_slots.size() - 1)]));
            else
                send_word(random_box(span, reach));
            if ($urandom_range(199) == 0)
                drain_block();
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        send_idle_pct   <= 25;
        recv_stall_pct  <= 25;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_WRITE;
        in_ch.slot      <= '0;
        in_ch.pos_x     <= '0;
        in_ch.pos_y     <= '0;
        in_ch.box_min_x <= '0;
        in_ch.box_max_x <= '0;
        in_ch.box_min_y <= '0;
        in_ch.box_max_y <= '0;
        in_ch.collides  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_slot_count(4);
        send_word(box_write(0, 0, 0, -10, 10, -10, 10, 1'b1));
        // touches slot 0 on one edge only
        send_word(box_write(1, 20, 0, -10, 10, -10, 10, 1'b1));
        send_word(box_write(2, -32768, -32768, -32768, 32767, -32768, 32767, 1'b0));
        // all edges wrap around to a small box just left of and above the origin
        send_word(box_write(3, 32767, 32767, 32767, -32768, 32767, -32768, 1'b1));
        send_word(box_write(255, -100, -100, 0, 0, 0, 0, 1'b1));
        send_word(box_query(0));
        send_word(box_query(1));
        send_word(box_query(2));
        send_word(box_query(3));
        send_word(box_query(255));
        send_word(box_write(1, 20, 0, -10, 10, -10, 10, 1'b0));
        send_word(box_query(0));
        set_slot_count(0);
        send_word(box_query(0));
        set_slot_count(1);
        send_word(box_query(0));
        send_word(box_query(3));

        run_phase(1, 60, 4000, 800, 1'b0);
        run_phase(2, 60, 200, 150, 1'b0);
        run_phase(256, 150, 30000, 600, 1'b0);
        run_phase(511, 120, 2000, 100, 1'b0);
        run_phase(0, 80, 500, 500, 1'b0);
        run_phase(17, 120, 300, 40, 1'b0);
        run_phase(256, 150, 8000, 300, 1'b0);
        run_phase(64, 150, 1000, 60, 1'b0);
        run_phase(3, 150, 50, 30, 1'b0);
        run_phase(128, 150, 20000, 2000, 1'b0);
        run_phase(200, 160, 3000, 120, 1'b1);

        drain_block();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
